>>> hw/rtl/bcs_pkg.sv
`default_nettype none
package bcs_pkg;

  localparam int MaxPoints  = 33;
  localparam int MaxSamples = 64;
  localparam int CntW       = 6;
  localparam int WgtW       = 32;
  localparam int CrdW       = 32;
  localparam int ParW       = 31;

  localparam logic [WgtW-1:0] OneQ30 = WgtW'(1) << 30;

  // register slots on the configuration port
  localparam logic RegSampleCount = 1'b0;
  localparam logic RegThreeD      = 1'b1;

  // per-cycle command to every weight cell
  typedef struct packed {
    logic load;
    logic raise;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/bezier_curve_sampler_top.sv
`default_nettype none
// channel | direction | handshake           | payload
// points  | in        | in_valid_i/in_stall_o | point_x/y/z_i, last_point_i
// curve   | out       | out_valid_o/out_stall_i | curve_x/y/z_o, last_sample_o
// config  | apb       | psel/penable/pready | sample_count (0x0), three_d (0x4)
// a plain point is stored while idle; a flagged last point starts a run that
// first divides out the reciprocal, then forms each sample (n points) by the
// weight cell chain raise and the serial weighted sum.
// rst_ni clears the control state; the point store is not cleared.
// points are refused for the whole run; a stalled output holds the next sample.
module bezier_curve_sampler_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [bcs_pkg::CrdW-1:0]  point_x_i,
  input  logic signed [bcs_pkg::CrdW-1:0]  point_y_i,
  input  logic signed [bcs_pkg::CrdW-1:0]  point_z_i,
  input  logic                             last_point_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [bcs_pkg::CrdW-1:0]  curve_x_o,
  output logic signed [bcs_pkg::CrdW-1:0]  curve_y_o,
  output logic signed [bcs_pkg::CrdW-1:0]  curve_z_o,
  output logic                             last_sample_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import bcs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_INIT, ST_RAISE, ST_SUM, ST_OUT
  } state_e;

  state_e          state_q;
  logic [6:0]      sc_q;
  logic            td_q;
  logic [CntW-1:0] lc_q, cnt_q, idx_q, rcnt_q, k_q, m_q;
  logic            a_valid_q, b_valid_q;
  logic [WgtW-1:0] a_w_q;
  logic [3*CrdW-1:0] mem_q [MaxPoints];
  logic [3*CrdW-1:0] rd_q;
  logic            out_valid_q, out_last_q;
  logic signed [CrdW-1:0] ox_q, oy_q, oz_q;

  logic            in_acc, cfg_wr, out_free, div_start, t_step;
  logic [CntW-1:0] m_d;
  logic [6:0]      s_clamp;
  cell_ctl_t       ctl;
  logic [ParW-1:0] t, u;
  logic            div_busy;
  logic [WgtW-1:0] w_chain [MaxPoints];
  logic signed [CrdW-1:0] rx, ry, rz;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign out_free   = !out_valid_q || !out_stall_i;

  // register read back
  always_comb begin
    case (paddr[2])
      RegSampleCount: prdata = {25'd0, sc_q};
      RegThreeD:      prdata = {31'd0, td_q};
      default:        prdata = '0;
    endcase
  end

  // sample count clamped to its legal range
  always_comb begin
    if (sc_q < 7'd2) begin
      s_clamp = 7'd2;
    end else if (sc_q > 7'(MaxSamples)) begin
      s_clamp = 7'(MaxSamples);
    end else begin
      s_clamp = sc_q;
    end
    m_d = CntW'(s_clamp - 7'd1);
  end

  assign div_start = in_acc && last_point_i;
  assign t_step    = (state_q == ST_OUT) && out_free && (k_q != m_q);

  always_comb begin
    ctl.load  = (state_q == ST_INIT);
    ctl.raise = (state_q == ST_RAISE);
    ctl.shift = (state_q == ST_SUM);
  end

  bcs_param u_param (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .m_i     (m_d),
    .step_i  (t_step),
    .busy_o  (div_busy),
    .t_o     (t),
    .u_o     (u)
  );

  // chain of weight cells, cell 0 seeded with one
  for (genvar j = 0; j < MaxPoints; j++) begin : g_cell
    logic [WgtW-1:0] lo, hi;
    if (j == 0) begin : g_first
      assign lo = '0;
    end else begin : g_mid
      assign lo = w_chain[j-1];
    end
    if (j == MaxPoints-1) begin : g_last
      assign hi = '0;
    end else begin : g_inner
      assign hi = w_chain[j+1];
    end
    bcs_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .seed_i ((j == 0) ? OneQ30 : '0),
      .t_i    (t),
      .u_i    (u),
      .w_lo_i (lo),
      .w_hi_i (hi),
      .w_o    (w_chain[j])
    );
  end

  // point store and its registered read
  always_ff @(posedge clk_i) begin
    if (in_acc && (lc_q < CntW'(MaxPoints))) begin
      mem_q[lc_q] <= {point_z_i, point_y_i, point_x_i};
    end
    rd_q  <= mem_q[idx_q];
    a_w_q <= w_chain[0];
  end

  bcs_mac u_mac_x (
    .clk_i (clk_i), .clr_i (ctl.load), .mul_en_i (a_valid_q), .acc_en_i (b_valid_q),
    .w_i (a_w_q), .p_i ($signed(rd_q[CrdW-1:0])), .res_o (rx)
  );
  bcs_mac u_mac_y (
    .clk_i (clk_i), .clr_i (ctl.load), .mul_en_i (a_valid_q), .acc_en_i (b_valid_q),
    .w_i (a_w_q), .p_i ($signed(rd_q[2*CrdW-1:CrdW])), .res_o (ry)
  );
  bcs_mac u_mac_z (
    .clk_i (clk_i), .clr_i (ctl.load), .mul_en_i (a_valid_q), .acc_en_i (b_valid_q),
    .w_i (a_w_q), .p_i ($signed(rd_q[3*CrdW-1:2*CrdW])), .res_o (rz)
  );

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sc_q        <= 7'd16;
      td_q        <= 1'b1;
      lc_q        <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      rcnt_q      <= '0;
      k_q         <= '0;
      m_q         <= '0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      ox_q        <= '0;
      oy_q        <= '0;
      oz_q        <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          RegSampleCount: sc_q <= pwdata[6:0];
          RegThreeD:      td_q <= pwdata[0];
          default:        ;
        endcase
      end
      // output valid: load a new sample or drop after its transfer
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      a_valid_q <= (state_q == ST_SUM) && (idx_q != cnt_q);
      b_valid_q <= a_valid_q;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (lc_q < CntW'(MaxPoints)) begin
              lc_q  <= lc_q + CntW'(1);
              cnt_q <= lc_q + CntW'(1);
            end else begin
              cnt_q <= lc_q;
            end
            if (last_point_i) begin
              m_q     <= m_d;
              k_q     <= '0;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (!div_busy) begin
            state_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          rcnt_q <= cnt_q - CntW'(1);
          idx_q  <= '0;
          state_q <= (cnt_q == CntW'(1)) ? ST_SUM : ST_RAISE;
        end
        ST_RAISE: begin
          rcnt_q <= rcnt_q - CntW'(1);
          if (rcnt_q == CntW'(1)) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (idx_q != cnt_q) begin
            idx_q <= idx_q + CntW'(1);
          end else if (!a_valid_q && !b_valid_q) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            ox_q        <= rx;
            oy_q        <= ry;
            oz_q        <= td_q ? rz : '0;
            out_last_q  <= (k_q == m_q);
            if (k_q == m_q) begin
              lc_q    <= '0;
              state_q <= ST_IDLE;
            end else begin
              k_q     <= k_q + CntW'(1);
              state_q <= ST_INIT;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign curve_x_o     = ox_q;
  assign curve_y_o     = oy_q;
  assign curve_z_o     = oz_q;
  assign last_sample_o = out_last_q;

endmodule
`default_nettype wire

>>> hw/rtl/bcs_cell.sv
`default_nettype none
module bcs_cell (
  input  logic                      clk_i,
  input  bcs_pkg::cell_ctl_t        ctl_i,
  input  logic [bcs_pkg::WgtW-1:0]  seed_i,
  input  logic [bcs_pkg::ParW-1:0]  t_i,
  input  logic [bcs_pkg::ParW-1:0]  u_i,
  input  logic [bcs_pkg::WgtW-1:0]  w_lo_i,
  input  logic [bcs_pkg::WgtW-1:0]  w_hi_i,
  output logic [bcs_pkg::WgtW-1:0]  w_o
);
  import bcs_pkg::*;

  logic [WgtW-1:0]      w_q, w_d;
  logic [ParW+WgtW-1:0] prod_u, prod_t;
  logic [63:0]          sum;

  // degree raise: u*own + t*lower neighbour, rounded to nearest
  assign prod_u = u_i * w_q;
  assign prod_t = t_i * w_lo_i;
  assign sum    = 64'(prod_u) + 64'(prod_t) + (64'd1 << 29);

  always_comb begin
    w_d = w_q;
    if (ctl_i.load) begin
      w_d = seed_i;
    end else if (ctl_i.raise) begin
      w_d = sum[61:30];
    end else if (ctl_i.shift) begin
      w_d = w_hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  assign w_o = w_q;

endmodule
`default_nettype wire

>>> hw/rtl/bcs_param.sv
`default_nettype none
module bcs_param (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bcs_pkg::CntW-1:0]  m_i,
  input  logic                      step_i,
  output logic                      busy_o,
  output logic [bcs_pkg::ParW-1:0]  t_o,
  output logic [bcs_pkg::ParW-1:0]  u_o
);
  import bcs_pkg::*;

  logic            busy_q;
  logic [4:0]      bit_q;
  logic [CntW:0]   drem_q;
  logic [ParW-1:0] quo_q;
  logic [CntW-1:0] m_q;
  logic [ParW-1:0] t_q;
  logic [CntW-1:0] trem_q;
  logic [CntW:0]   shifted;
  logic [CntW:0]   tsum;

  // restoring division of 2^30 by m, one quotient bit a cycle
  assign shifted = {drem_q[CntW-1:0], (bit_q == 5'd30)};
  // running remainder for t = round(k*2^30/m)
  assign tsum    = {1'b0, trem_q} + drem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      bit_q  <= 5'd30;
    end else if (busy_q) begin
      bit_q <= bit_q - 5'd1;
      if (bit_q == 5'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q    <= m_i;
      drem_q <= '0;
      quo_q  <= '0;
      t_q    <= '0;
      trem_q <= m_i >> 1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, m_q}) begin
        drem_q <= shifted - {1'b0, m_q};
        quo_q  <= {quo_q[ParW-2:0], 1'b1};
      end else begin
        drem_q <= shifted;
        quo_q  <= {quo_q[ParW-2:0], 1'b0};
      end
    end else if (step_i) begin
      if (tsum >= {1'b0, m_q}) begin
        t_q    <= t_q + quo_q + ParW'(1);
        trem_q <= CntW'(tsum - {1'b0, m_q});
      end else begin
        t_q    <= t_q + quo_q;
        trem_q <= tsum[CntW-1:0];
      end
    end
  end

  assign busy_o = busy_q;
  assign t_o    = t_q;
  assign u_o    = ParW'(OneQ30) - t_q;

endmodule
`default_nettype wire

>>> hw/rtl/bcs_mac.sv
`default_nettype none
module bcs_mac (
  input  logic                             clk_i,
  input  logic                             clr_i,
  input  logic                             mul_en_i,
  input  logic                             acc_en_i,
  input  logic [bcs_pkg::WgtW-1:0]         w_i,
  input  logic signed [bcs_pkg::CrdW-1:0]  p_i,
  output logic signed [bcs_pkg::CrdW-1:0]  res_o
);
  import bcs_pkg::*;

  logic signed [WgtW:0]   w_s;
  logic signed [2*CrdW:0] mul;
  logic signed [63:0]     prod_q;
  logic signed [63:0]     acc_q;
  logic [63:0]            biased;
  logic signed [34:0]     rnd;

  // weight as a positive signed operand, full-width product
  assign w_s = $signed({1'b0, w_i});
  assign mul = w_s * p_i;

  // weight times coordinate, then accumulate
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= mul[63:0];
    end
    if (clr_i) begin
      acc_q <= '0;
    end else if (acc_en_i) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // round to nearest, ties up, then saturate
  assign biased = acc_q + 64'h8000_0000_2000_0000;
  assign rnd    = $signed({1'b0, biased[63:30]}) - 35'sh2_0000_0000;

  always_comb begin
    if (rnd > 35'sh0_7FFF_FFFF) begin
      res_o = 32'sh7FFF_FFFF;
    end else if (rnd < -35'sh0_8000_0000) begin
      res_o = -32'sh8000_0000;
    end else begin
      res_o = rnd[31:0];
    end
  end

endmodule
`default_nettype wire

>>> test/bezier_curve_sampler_top_tb.sv
module bezier_curve_sampler_top_tb;
  import bcs_pkg::*;

  localparam int ClkPeriod = 10;
  localparam longint CycleLimit = 4000000;
  localparam int SettleCycles = 40;
  localparam logic [31:0] QOne = 32'h4000_0000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } sample_t;

  // bernstein curve predictor and store of expected curve points
  class curve_scoreboard;
    logic [31:0] pt_x[MaxPoints];
    logic [31:0] pt_y[MaxPoints];
    logic [31:0] pt_z[MaxPoints];
    int          held;
    int          sample_cfg;
    bit          use_z;
    sample_t     pending[$];
    int          mismatches;
    int          samples_seen;
    int          curves;
    int          points;
    int          dropped;

    function new();
      held = 0;
      sample_cfg = 16;
      use_z = 1'b1;
      mismatches = 0;
      samples_seen = 0;
      curves = 0;
      points = 0;
      dropped = 0;
    endfunction

    function logic [31:0] weighted_sum(ref logic [31:0] pts[MaxPoints],
                                       ref logic [63:0] w[MaxPoints], input int cnt);
      logic [63:0] acc;
      logic [63:0] q;
      longint      r;
      acc = '0;
      for (int i = 0; i < cnt; i++) acc += w[i] * {{32{pts[i][31]}}, pts[i]};
      q = (acc + 64'h8000_0000_0000_0000 + 64'h2000_0000) >> 30;
      r = longint'(q) - (longint'(1) <<< 33);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    // stores a transferred point and predicts the curve when it closes the polygon
    function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      logic [63:0] w[MaxPoints];
      logic [63:0] t, u, prev;
      int s, m;
      sample_t e;
      points++;
      if (held < MaxPoints) begin
        pt_x[held] = x;
        pt_y[held] = y;
        pt_z[held] = z;
        held++;
      end else begin
        dropped++;
      end
      if (!last) return;
      s = sample_cfg;
      if (s < 2) s = 2;
      if (s > MaxSamples) s = MaxSamples;
      m = s - 1;
      for (int k = 0; k < s; k++) begin
        t = (64'(k) * 64'(QOne) + 64'(m / 2)) / 64'(m);
        u = 64'(QOne) - t;
        for (int i = 0; i < MaxPoints; i++) w[i] = '0;
        w[0] = 64'(QOne);
        for (int r = 1; r < held; r++) begin
          for (int j = r; j >= 0; j--) begin
            prev = (j > 0) ? w[j-1] : '0;
            w[j] = (u * w[j] + t * prev + 64'h2000_0000) >> 30;
          end
        end
        e.x = weighted_sum(pt_x, w, held);
        e.y = weighted_sum(pt_y, w, held);
        e.z = use_z ? weighted_sum(pt_z, w, held) : '0;
        e.last = (k == m);
        pending.insert(pending.size(), e);
      end
      held = 0;
      curves++;
    endfunction

    function void check_sample(sample_t act);
      sample_t e;
      samples_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected curve point x=%h y=%h z=%h last=%b",
                   act.x, act.y, act.z, act.last);
        return;
      end
      e = pending.pop_front();
      if (act != e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("curve point mismatch: exp x=%h y=%h z=%h last=%b, got x=%h y=%h z=%h last=%b",
                   e.x, e.y, e.z, e.last, act.x, act.y, act.z, act.last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] point_x_i, point_y_i, point_z_i;
  logic        last_point_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] curve_x_o, curve_y_o, curve_z_o;
  logic        last_sample_o;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  curve_scoreboard sb = new();
  longint cycles;
  int     hold_req;
  bit     quiet_out;

  bezier_curve_sampler_top dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .point_x_i, .point_y_i, .point_z_i, .last_point_i,
    .out_valid_o, .out_stall_i,
    .curve_x_o, .curve_y_o, .curve_z_o, .last_sample_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // clock and run limit
  initial begin
    clk_i = 1'b0;
    cycles = 0;
    forever begin
      #(ClkPeriod / 2) clk_i = 1'b1;
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("bezier_curve_sampler_top_tb failed");
        $finish;
      end
      #(ClkPeriod / 2) clk_i = 1'b0;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_sample('{curve_x_o, curve_y_o, curve_z_o, last_sample_o});
  end

  // receiver stalls: short bursts, rare long ones, one forced long hold
  initial begin
    int run;
    run = 0;
    out_stall_i = 1'b0;
    hold_req = 0;
    quiet_out = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        out_stall_i <= 1'b1;
        hold_req--;
      end else if (run > 0) begin
        run--;
      end else if (quiet_out) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
      3, 4: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // one point transfer, with a random gap before it
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last,
                            bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(0, 2));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    point_z_i    <= z;
    last_point_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_point(x, y, z, last);
  endtask

  task automatic send_polygon(int n);
    for (int i = 0; i < n; i++)
      send_point(pick_coord(), pick_coord(), pick_coord(), i == n - 1);
  endtask

  task automatic finish_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    finish_input();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == {RegSampleCount, 2'b00}) sb.sample_cfg = data[6:0];
    else if (addr == {RegThreeD, 2'b00}) sb.use_z = data[0];
  endtask

  task automatic configure(int samples, bit z_on);
    wait_drained();
    reg_write({RegSampleCount, 2'b00}, 32'(samples));
    reg_write({RegThreeD, 2'b00}, 32'(z_on));
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(30, 36);
    if (r < 4) return $urandom_range(7, 16);
    return $urandom_range(1, 6);
  endfunction

  initial begin
    int sent;
    int sizes[8];
    sizes = '{2, 0, 1, 64, 127, 5, 3, 9};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    last_point_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, single points at the extremes
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b1);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
    // straight line between extremes, and a lone unflagged point then flag
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000, 1'b1);
    configure(4, 1'b0);
    // full store, then extra points dropped with the flag on a dropped one
    for (int i = 0; i < 35; i++)
      send_point(32'h7fff_ffff, 32'h8000_0000, pick_coord(), i == 34, 1'b1);
    configure(3, 1'b1);
    // exactly full store with the flag on the last held point
    for (int i = 0; i < MaxPoints; i++)
      send_point(pick_coord(), pick_coord(), pick_coord(), i == MaxPoints - 1, 1'b1);
    sent = 4 + 35 + MaxPoints;

    // random phases through the register settings
    for (int ph = 0; ph < 8; ph++) begin
      configure(sizes[ph], $urandom_range(0, 1));
      quiet_out = (ph == 6);
      if (ph == 2) begin
        // long receiver hold while points keep coming
        hold_req = 3000;
        for (int c = 0; c < 4; c++) begin
          int n;
          n = $urandom_range(1, 4);
          send_polygon(n);
          sent += n;
        end
      end
      for (int c = 0; c < ((sizes[ph] >= 64) ? 2 : 5); c++) begin
        int n;
        n = (sizes[ph] >= 64) ? $urandom_range(1, 8) : pick_size();
        send_polygon(n);
        sent += n;
        // sender pause until every curve point has arrived
        if (c == 3) begin
          finish_input();
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
      end
    end
    configure($urandom_range(2, 12), 1'b1);
    while (sent < 300) begin
      int n;
      n = pick_size();
      send_polygon(n);
      sent += n;
    end
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("%0d points transferred (%0d dropped on a full store), %0d curves, %0d samples",
             sb.points, sb.dropped, sb.curves, sb.samples_seen);
    $display("sample counts clamped at both ends, planar and 3d, long stalls on both sides");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("bezier_curve_sampler_top_tb passed");
    end else begin
      $display("%0d mismatches, %0d curve points missing", sb.mismatches, sb.pending.size());
      $display("bezier_curve_sampler_top_tb failed");
    end
    $finish;
  end

endmodule
